@@ design/asbd_pkg.sv @@
// ----------------------------------------------------------------------------
// asbd_pkg
// Shared types, opcodes and constants of the audio stream buffer device.
// ----------------------------------------------------------------------------
package asbd_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 65536;
  localparam int unsigned OFFSET_SPAN      = 65536;
  localparam int unsigned SHIFT_W          = 4;

  localparam logic [1:0] OP_CTRL_RD = 2'd0;
  localparam logic [1:0] OP_CTRL_WR = 2'd1;
  localparam logic [1:0] OP_BUF_WR  = 2'd2;
  localparam logic [1:0] OP_PLAY    = 2'd3;

  localparam logic [2:0] NUM_CTRL  = 3'd6;
  localparam logic [2:0] IDX_SIZE  = 3'd3;
  localparam logic [2:0] IDX_INIT  = 3'd4;
  localparam logic [2:0] IDX_COUNT = 3'd5;
  localparam logic [2:0] MAX_LEN   = 3'd4;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  reg_index;
    logic [15:0] buf_offset;
    logic [31:0] write_data;
    logic [2:0]  write_len;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [7:0]  play_byte;
    logic        play_real;
  } out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        idx_ok;
    logic [2:0]  idx;
    logic [15:0] off;
    logic [31:0] data;
    logic [2:0]  len;
  } cmd_t;

  // number of compare/subtract steps that bring a 16-bit offset below b
  function automatic int unsigned red_steps(input int unsigned b);
    int unsigned n;
    n = 0;
    while ((b << n) < OFFSET_SPAN) begin
      n = n + 1;
    end
    return n;
  endfunction

endpackage

@@ design/audio_stream_buffer_device.sv @@
// ----------------------------------------------------------------------------
// audio_stream_buffer_device
// Audio playback ring buffer: control words, byte stream store, play port.
// ----------------------------------------------------------------------------
// Each transaction on in_ gives exactly one result on out_. A two-entry
// command queue sits between the decode front and the execution back. The
// result register lets a buffer write go on storing bytes while its result
// waits; any other new command starts only once the waiting result is taken,
// at the earliest in the same cycle. Control reads, control writes, buffer
// writes of length zero and plays with nothing queued register their result
// as they leave the queue; a play reads the sample memory through a
// register first. A buffer write wraps its offset into the buffer in R
// compare/subtract steps, then stores its L clamped bytes, one byte per
// cycle through the single memory write port. R is 0 when BUFFER_BYTES is
// at least 65536, else the number of left shifts of BUFFER_BYTES that stay
// below 65536. Reading a sample never written is undefined.
module audio_stream_buffer_device #(
  parameter int unsigned BUFFER_BYTES = asbd_pkg::BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  asbd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output asbd_pkg::out_t out_data
);
  import asbd_pkg::*;

  logic cmd_valid;
  cmd_t cmd_data;
  logic cmd_pop;

  asbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop)
  );

  asbd_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ design/asbd_front.sv @@
// ----------------------------------------------------------------------------
// asbd_front
// Accepts transactions, decodes them into commands and queues them (2 deep).
// ----------------------------------------------------------------------------
module asbd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  asbd_pkg::in_t  in_data,
  output logic           cmd_valid,
  output asbd_pkg::cmd_t cmd_data,
  input  logic           cmd_pop
);
  import asbd_pkg::*;

  cmd_t       q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push;

  always_comb begin
    dec.kind   = in_data.opcode;
    dec.idx    = in_data.reg_index;
    dec.idx_ok = (in_data.reg_index < NUM_CTRL);
    dec.off    = in_data.buf_offset;
    dec.data   = in_data.write_data;
    dec.len    = (in_data.write_len > MAX_LEN) ? MAX_LEN : in_data.write_len;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = q_r[rptr_r];
  assign push      = in_valid && in_ready;

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = cmd_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= dec;
    end
  end

endmodule

@@ design/asbd_back.sv @@
// ----------------------------------------------------------------------------
// asbd_back
// Executes queued commands: control words, sample store, play ring, result.
// ----------------------------------------------------------------------------
module asbd_back #(
  parameter int unsigned BUFFER_BYTES = asbd_pkg::BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  asbd_pkg::cmd_t cmd_data,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output asbd_pkg::out_t out_data
);
  import asbd_pkg::*;

  localparam int unsigned AW        = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
  localparam int unsigned CW        = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned RED_STEPS = red_steps(BUFFER_BYTES);
  localparam logic [AW-1:0] LAST    = AW'(BUFFER_BYTES - 1);
  localparam logic [CW:0]   CAP     = (CW + 1)'(BUFFER_BYTES);
  localparam logic [31:0]   SIZE32  = 32'(BUFFER_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;
  localparam logic [1:0] S_PLAY = 2'd3;

  logic [7:0]         mem [0:BUFFER_BYTES-1];
  logic [1:0]         state_r, state_nxt;
  logic [31:0]        ctrl_r [6];
  logic [31:0]        ctrl_nxt [6];
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [15:0]        rem_r, rem_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [AW-1:0]      waddr_r, waddr_nxt;
  logic [31:0]        wdata_r, wdata_nxt;
  logic [2:0]         left_r, left_nxt;
  logic [7:0]         rdata_r;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic               mem_we;
  logic               out_free;
  logic [CW:0]        sum;
  logic [31:0]        sub;
  logic [31:0]        rem_ext;
  logic [15:0]        rem_step;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    ctrl_nxt      = ctrl_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    shift_nxt     = shift_r;
    waddr_nxt     = waddr_r;
    wdata_nxt     = wdata_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    sum           = {1'b0, cnt_r} + (CW + 1)'(cmd_data.len);
    sub           = SIZE32 << shift_r;
    rem_ext       = {16'd0, rem_r};
    rem_step      = (rem_ext >= sub) ? 16'(rem_ext - sub) : rem_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop       = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          unique case (cmd_data.kind)
            OP_CTRL_RD: begin
              if (cmd_data.idx_ok) begin
                priority if (cmd_data.idx == IDX_SIZE) begin
                  ctrl_nxt[IDX_SIZE]     = SIZE32;
                  out_data_nxt.read_data = SIZE32;
                end else if (cmd_data.idx == IDX_COUNT) begin
                  ctrl_nxt[IDX_COUNT]    = 32'(cnt_r);
                  out_data_nxt.read_data = 32'(cnt_r);
                end else begin
                  out_data_nxt.read_data = ctrl_r[cmd_data.idx];
                end
              end
            end
            OP_CTRL_WR: begin
              if (cmd_data.idx_ok) begin
                ctrl_nxt[cmd_data.idx] = cmd_data.data;
                if (cmd_data.idx == IDX_INIT) begin
                  pos_nxt = '0;
                  cnt_nxt = '0;
                end
              end
            end
            OP_BUF_WR: begin
              if (cmd_data.len != 3'd0) begin
                cnt_nxt   = (sum > CAP) ? CW'(CAP) : CW'(sum);
                rem_nxt   = cmd_data.off;
                wdata_nxt = cmd_data.data;
                left_nxt  = cmd_data.len;
                if (RED_STEPS > 0) begin
                  shift_nxt = SHIFT_W'(RED_STEPS - 1);
                  state_nxt = S_RED;
                end else begin
                  waddr_nxt = AW'(cmd_data.off);
                  state_nxt = S_WR;
                end
              end
            end
            OP_PLAY: begin
              if (cnt_r != '0) begin
                out_valid_nxt = 1'b0;
                pos_nxt       = (pos_r == LAST) ? '0 : pos_r + 1'b1;
                cnt_nxt       = cnt_r - 1'b1;
                state_nxt     = S_PLAY;
              end
            end
          endcase
        end
      end
      S_RED: begin
        rem_nxt   = rem_step;
        shift_nxt = shift_r - 1'b1;
        if (shift_r == '0) begin
          waddr_nxt = AW'(rem_step);
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        waddr_nxt = (waddr_r == LAST) ? '0 : waddr_r + 1'b1;
        wdata_nxt = wdata_r >> 8;
        left_nxt  = left_r - 1'b1;
        if (left_r == 3'd1) begin
          state_nxt = S_IDLE;
        end
      end
      S_PLAY: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.read_data = '0;
        out_data_nxt.play_byte = rdata_r;
        out_data_nxt.play_real = 1'b1;
        state_nxt              = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctrl_r      <= '{default: '0};
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctrl_r      <= ctrl_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    shift_r    <= shift_nxt;
    waddr_r    <= waddr_nxt;
    wdata_r    <= wdata_nxt;
    left_r     <= left_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr_r] <= wdata_r[7:0];
    end
    rdata_r <= mem[pos_r];
  end

endmodule

@@ tb/tb_audio_stream_buffer_device.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_stream_buffer_device
// Self-checking bench for the audio playback ring buffer. A short directed
// run hits every control word, the out-of-range indexes, odd write lengths,
// offset wrap and silence; random stream traffic follows under three idling
// schemes. Every result is compared with an in-bench model of the device.
// ----------------------------------------------------------------------------
module tb_audio_stream_buffer_device;
  import asbd_pkg::*;

  localparam int unsigned BUF_BYTES   = BUFFER_BYTES_DEF;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AT     = 150;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned TAIL_CYCLES = 20;

  localparam logic [2:0] IDX_FREQ     = 3'd0;
  localparam logic [2:0] IDX_CHANNELS = 3'd1;
  localparam logic [2:0] IDX_SAMPLES  = 3'd2;
  localparam logic [2:0] IDX_UNUSED_A = 3'd6;
  localparam logic [2:0] IDX_UNUSED_B = 3'd7;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  audio_stream_buffer_device #(
    .BUFFER_BYTES(BUF_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // device model state
  logic [31:0] ctrl_words [NUM_CTRL] = '{default: '0};
  logic [7:0]  sample_mem [BUF_BYTES];
  int unsigned play_pos     = 0;
  int unsigned queued_count = 0;

  // stimulus bookkeeping: keeps plays away from bytes never stored
  bit          gen_written [BUF_BYTES];
  int unsigned gen_pos   = 0;
  int unsigned gen_count = 0;
  int unsigned wr_ptr    = 0;

  in_t  bus_requests[$];
  out_t expected_results[$];

  int unsigned offered_total  = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen   = 0;
  int unsigned fail_count     = 0;
  int unsigned send_idle_pct  = 26;
  int unsigned recv_idle_pct  = 56;
  int unsigned hold_left      = 0;
  bit          hold_done      = 1'b0;
  int unsigned quiet_cycles   = 0;

  function automatic out_t device_response(input in_t req);
    out_t        rsp;
    int unsigned n;
    int unsigned i;
    rsp = '0;
    case (req.opcode)
      OP_CTRL_RD: begin
        if (req.reg_index < NUM_CTRL) begin
          if (req.reg_index == IDX_SIZE) begin
            ctrl_words[IDX_SIZE] = BUF_BYTES;
          end else if (req.reg_index == IDX_COUNT) begin
            ctrl_words[IDX_COUNT] = queued_count;
          end
          rsp.read_data = ctrl_words[req.reg_index];
        end
      end
      OP_CTRL_WR: begin
        if (req.reg_index < NUM_CTRL) begin
          ctrl_words[req.reg_index] = req.write_data;
          if (req.reg_index == IDX_INIT) begin
            play_pos     = 0;
            queued_count = 0;
          end
        end
      end
      OP_BUF_WR: begin
        n = (req.write_len > MAX_LEN) ? MAX_LEN : req.write_len;
        for (i = 0; i < n; i++) begin
          sample_mem[(req.buf_offset + i) % BUF_BYTES] = req.write_data[8*i +: 8];
        end
        queued_count = queued_count + n;
        if (queued_count > BUF_BYTES) begin
          queued_count = BUF_BYTES;
        end
      end
      OP_PLAY: begin
        if (queued_count != 0) begin
          rsp.play_byte = sample_mem[play_pos];
          rsp.play_real = 1'b1;
          play_pos      = (play_pos + 1) % BUF_BYTES;
          queued_count  = queued_count - 1;
        end
      end
    endcase
    return rsp;
  endfunction

  function automatic in_t make_req(input logic [1:0] op, input logic [2:0] idx,
                                   input logic [15:0] off, input logic [31:0] data,
                                   input logic [2:0] len);
    in_t req;
    req.opcode     = op;
    req.reg_index  = idx;
    req.buf_offset = off;
    req.write_data = data;
    req.write_len  = len;
    return req;
  endfunction

  task automatic offer(input in_t req);
    int unsigned n;
    int unsigned i;
    if (req.opcode == OP_PLAY && gen_count != 0 && !gen_written[gen_pos]) begin
      // store the byte first instead of playing an unwritten one
      req.opcode     = OP_BUF_WR;
      req.buf_offset = gen_pos[15:0];
      req.write_len  = 3'd1;
    end
    case (req.opcode)
      OP_CTRL_WR: begin
        if (req.reg_index == IDX_INIT) begin
          gen_pos   = 0;
          gen_count = 0;
          wr_ptr    = 0;
        end
      end
      OP_BUF_WR: begin
        n = (req.write_len > MAX_LEN) ? MAX_LEN : req.write_len;
        for (i = 0; i < n; i++) begin
          gen_written[(req.buf_offset + i) % BUF_BYTES] = 1'b1;
        end
        gen_count = (gen_count + n > BUF_BYTES) ? BUF_BYTES : gen_count + n;
      end
      OP_PLAY: begin
        if (gen_count != 0) begin
          gen_pos   = (gen_pos + 1) % BUF_BYTES;
          gen_count = gen_count - 1;
        end
      end
      default: begin
      end
    endcase
    bus_requests.push_back(req);
    offered_total++;
  endtask

  task automatic stream_items(input int unsigned count);
    in_t         req;
    int unsigned pick;
    logic [2:0]  len;
    logic [2:0]  idx;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        req = make_req(2'($urandom_range(3)), 3'($urandom_range(7)), 16'($urandom),
                       $urandom, 3'($urandom_range(7)));
      end else if (pick < 50) begin
        len    = 3'($urandom_range(4, 1));
        req    = make_req(OP_BUF_WR, 3'($urandom_range(7)), wr_ptr[15:0], $urandom, len);
        wr_ptr = (wr_ptr + len) % BUF_BYTES;
      end else if (pick < 85) begin
        req = make_req(OP_PLAY, 3'($urandom_range(7)), 16'($urandom), $urandom,
                       3'($urandom_range(7)));
      end else if (pick < 93) begin
        req = make_req(OP_CTRL_RD, 3'($urandom_range(5)), 16'($urandom), $urandom,
                       3'($urandom_range(7)));
      end else if (pick < 98) begin
        idx = 3'($urandom_range(4));
        if (idx >= IDX_INIT) begin
          idx = idx + 3'd1;
        end
        req = make_req(OP_CTRL_WR, idx, 16'($urandom), $urandom, 3'($urandom_range(7)));
      end else begin
        req = make_req(OP_CTRL_WR, IDX_INIT, 16'($urandom), $urandom,
                       3'($urandom_range(7)));
      end
      offer(req);
    end
  endtask

  task automatic drain_requests();
    while (accepted_count != offered_total) begin
      @(negedge clk);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    offer(make_req(OP_CTRL_RD, IDX_FREQ, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_SIZE, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_COUNT, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_UNUSED_B, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));
    offer(make_req(OP_PLAY, IDX_FREQ, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_WR, IDX_FREQ, 16'h0, 32'hFFFF_FFFF, 3'd0));
    offer(make_req(OP_CTRL_WR, IDX_CHANNELS, 16'h0, 32'h0000_0002, 3'd0));
    offer(make_req(OP_CTRL_WR, IDX_SAMPLES, 16'h0, 32'hA5A5_5A5A, 3'd0));
    offer(make_req(OP_CTRL_WR, IDX_SIZE, 16'h0, 32'h1234_5678, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_SIZE, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_WR, IDX_UNUSED_A, 16'h0, 32'hFFFF_FFFF, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_UNUSED_A, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_FREQ, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_BUF_WR, IDX_FREQ, 16'h0000, 32'hDDCC_BBAA, 3'd4));
    offer(make_req(OP_BUF_WR, IDX_FREQ, 16'h0004, 32'hFFFF_FFFF, 3'd0));
    offer(make_req(OP_BUF_WR, IDX_FREQ, 16'h0004, 32'h4433_2211, 3'd7));
    offer(make_req(OP_BUF_WR, IDX_FREQ, 16'hFFFE, 32'h807F_FF00, 3'd4));
    offer(make_req(OP_CTRL_WR, IDX_COUNT, 16'h0, 32'hFFFF_FFFF, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_COUNT, 16'h0, 32'h0, 3'd0));
    repeat (3) begin
      offer(make_req(OP_PLAY, IDX_FREQ, 16'h0, 32'h0, 3'd0));
    end
    offer(make_req(OP_CTRL_WR, IDX_INIT, 16'h0, 32'h0000_0001, 3'd0));
    offer(make_req(OP_PLAY, IDX_FREQ, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_INIT, 16'h0, 32'h0, 3'd0));
    offer(make_req(OP_CTRL_RD, IDX_COUNT, 16'h0, 32'h0, 3'd0));
    wr_ptr = 0;

    stream_items(520);
    drain_requests();
    send_idle_pct = 56;
    recv_idle_pct = 26;
    stream_items(520);
    drain_requests();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stream_items(510);
    drain_requests();

    while (expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(device_response(in_data));
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (bus_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= bus_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          if (fail_count < REPORT_MAX) begin
            $display("result %0d with no transaction pending: %h/%h/%b", results_seen,
                     out_data.read_data, out_data.play_byte, out_data.play_real);
          end
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.read_data !== want.read_data ||
              out_data.play_byte !== want.play_byte ||
              out_data.play_real !== want.play_real) begin
            if (fail_count < REPORT_MAX) begin
              $display("result %0d: read_data %h/%h play_byte %h/%h play_real %b/%b",
                       results_seen, want.read_data, out_data.read_data,
                       want.play_byte, out_data.play_byte,
                       want.play_real, out_data.play_real);
            end
            fail_count++;
          end
        end
      end
      // hold off the receiver once so the block backs up into its input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
